FILE: rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int MAG_W      = 32;
   localparam int CHAR_W     = 8;
   localparam int DIGIT_W    = 4;
   localparam int DIGITS_MAX = 10;
   localparam int DIG_IDX_W  = $clog2(DIGITS_MAX);
   localparam int PROD_W     = 2 * MAG_W;
   localparam int RECIP_SH   = 35;
   localparam int QUOT_W     = PROD_W - RECIP_SH;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
   localparam logic [DIGIT_W-1:0] DIGIT_BASE = 4'd10;
   // ceil(2^35 / 10): exact quotient by ten for every 32-bit operand
   localparam logic [MAG_W-1:0]   RECIP_TEN  = 32'hCCCC_CCCD;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } job_type;

endpackage

FILE: rtl/sitda_if.sv
// ----------------------------------------------------------------------------
// sitda_req_if / sitda_rsp_if
// Valid/ready channels carrying input integers and output characters.
// ----------------------------------------------------------------------------
interface sitda_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sitda_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

FILE: rtl/sitda_front.sv
// ----------------------------------------------------------------------------
// sitda_front
// Accepts words, splits them into sign and unsigned magnitude, holds one job.
// ----------------------------------------------------------------------------
module sitda_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [31:0]       in_value,
   output logic              job_valid,
   input  logic              job_ready,
   output sitda_pkg::job_type job
);
   import sitda_pkg::*;

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic    take;

   assign in_ready  = !valid_ff || job_ready;
   assign take      = in_valid && in_ready;
   assign job_valid = valid_ff;
   assign job       = job_ff;

   always_comb begin
      job_in.neg = in_value[MAG_W-1];
      // two's complement negate; the most negative value wraps to 2^31 unsigned
      job_in.mag = in_value[MAG_W-1] ? (MAG_W'(0) - in_value) : in_value;
      if (take) begin
         valid_in = 1'b1;
      end else if (job_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         job_ff <= job_in;
      end
   end

endmodule

FILE: rtl/sitda_queue.sv
// ----------------------------------------------------------------------------
// sitda_queue
// Two-entry job queue between the front and the back end.
// ----------------------------------------------------------------------------
module sitda_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  sitda_pkg::job_type wr_job,
   output logic               rd_valid,
   input  logic               rd_ready,
   output sitda_pkg::job_type rd_job
);
   import sitda_pkg::*;

   job_type    mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_job   = mem[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem[wr_ptr_ff] <= wr_job;
      end
   end

`ifndef SYNTH
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("queue count out of range");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("queue count did not follow push");
`endif

endmodule

FILE: rtl/sitda_back.sv
// ----------------------------------------------------------------------------
// sitda_back
// Splits a magnitude into decimal digits by reciprocal multiply, then emits
// the sign and the digits most significant first through an output register.
// ----------------------------------------------------------------------------
module sitda_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  sitda_pkg::job_type job,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_character,
   output logic               out_last
);
   import sitda_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FIX,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type            state_ff;
   logic                 neg_ff;
   logic [MAG_W-1:0]     mag_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [DIG_IDX_W-1:0] idx_ff;
   logic [DIGIT_W-1:0]   digits [DIGITS_MAX];
   logic                 out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]    out_char_ff;
   logic                 out_last_ff;

   logic [QUOT_W-1:0]    quot;
   logic [MAG_W-1:0]     quot_x10;
   logic [MAG_W-1:0]     rem;
   logic                 slot_free;
   logic                 char_load;

   assign job_ready     = (state_ff == ST_IDLE);
   assign out_valid     = out_valid_ff;
   assign out_character = out_char_ff;
   assign out_last      = out_last_ff;
   assign slot_free     = !out_valid_ff || out_ready;
   assign char_load     = ((state_ff == ST_SIGN) || (state_ff == ST_EMIT)) && slot_free;
   assign out_valid_in  = char_load || (out_valid_ff && !out_ready);

   // q = floor(mag / 10), remainder by shift-add of q * 10
   assign quot     = prod_ff[PROD_W-1:RECIP_SH];
   assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
   assign rem      = mag_ff - quot_x10;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  neg_ff   <= job.neg;
                  mag_ff   <= job.mag;
                  idx_ff   <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= PROD_W'(mag_ff) * PROD_W'(RECIP_TEN);
               state_ff <= ST_FIX;
            end
            ST_FIX: begin
               digits[idx_ff] <= rem[DIGIT_W-1:0];
               mag_ff         <= MAG_W'(quot);
               if (quot == '0) begin
                  state_ff <= neg_ff ? ST_SIGN : ST_EMIT;
               end else begin
                  idx_ff   <= idx_ff + DIG_IDX_W'(1);
                  state_ff <= ST_MUL;
               end
            end
            ST_SIGN: begin
               if (slot_free) begin
                  out_char_ff  <= CHAR_MINUS;
                  out_last_ff  <= 1'b0;
                  state_ff     <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (slot_free) begin
                  out_char_ff  <= CHAR_ZERO + {4'b0000, digits[idx_ff]};
                  out_last_ff  <= (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff <= idx_ff - DIG_IDX_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTH
   a_rem_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |-> (rem < MAG_W'(DIGIT_BASE)))
      else $error("reciprocal divide left remainder above nine");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff < DIG_IDX_W'(DIGITS_MAX))
      else $error("digit index beyond buffer");
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_char_ff == CHAR_MINUS) |-> !out_last_ff)
      else $error("sign flagged as final character");
   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      (job_valid && job_ready) |=> (state_ff == ST_MUL))
      else $error("job taken without starting conversion");
`endif

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Writes each signed 32-bit word as decimal ASCII text, sign first, MSD first.
// ----------------------------------------------------------------------------
// channel  dir  payload                      accepted when
// req_ch   in   value[31:0] signed           valid && ready
// rsp_ch   out  character[7:0], last         valid && ready
//
// The back end takes a job, then for each digit multiplies by the reciprocal
// of ten and fixes up the remainder, and then sends one character per cycle
// while rsp_ch is ready. It takes no new job until its last character is loaded.
// The front holds one word and a two-entry queue buffers two more, so up to
// three words are accepted while the back end converts or the output stalls.
// Reset is synchronous and clears all valid flags and the state machine.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input logic         clock,
   input logic         reset,
   sitda_req_if.sink   req_ch,
   sitda_rsp_if.source rsp_ch
);
   import sitda_pkg::*;

   logic    f_valid, f_ready;
   job_type f_job;
   logic    b_valid, b_ready;
   job_type b_job;

   sitda_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_value  (req_ch.value),
      .job_valid (f_valid),
      .job_ready (f_ready),
      .job       (f_job)
   );

   sitda_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_job   (f_job),
      .rd_valid (b_valid),
      .rd_ready (b_ready),
      .rd_job   (b_job)
   );

   sitda_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (b_valid),
      .job_ready     (b_ready),
      .job           (b_job),
      .out_valid     (rsp_ch.valid),
      .out_ready     (rsp_ch.ready),
      .out_character (rsp_ch.character),
      .out_last      (rsp_ch.last)
   );

endmodule
